// ===== src/upd_pkg.sv =====
// Package for the URL percent decoder: payload structs, decode state and constants.
// No dependencies; used by upd_decode and url_percent_decoder_top.
`default_nettype none

package upd_pkg;

  localparam int unsigned MAX_LEN = 4096;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX1 = 2'd2
  } upd_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        run_last;
    logic        string_end;
    logic        bad_escape;
    logic [12:0] unit_count;
  } upd_out_t;

  typedef struct packed {
    upd_phase_e  phase;
    logic [3:0]  high_nibble;
    logic [12:0] written_count;
    logic [12:0] units_seen;
    logic        error_seen;
  } upd_state_t;

endpackage

`default_nettype wire

// ===== src/upd_decode.sv =====
// Per-byte decode logic: next string state and up to two results for one input byte.
// Depends on upd_pkg.
`default_nettype none

module upd_decode (
  input  upd_pkg::upd_state_t st_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [12:0]         cap_i,
  output upd_pkg::upd_state_t st_o,
  output upd_pkg::upd_out_t   res0_o,
  output upd_pkg::upd_out_t   res1_o,
  output logic [1:0]          n_o
);

  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    // bit 4 set: b is a hex digit, low nibble is its value
    logic [7:0] t;
    t = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      return {1'b1, t[3:0]};
    end
    if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  logic [4:0]  hx;
  logic        active;
  logic        emit_lit;
  logic        do_plain;
  logic        emit_main;
  logic [7:0]  main_byte;
  logic [13:0] wc_plus1;
  logic [1:0]  n;
  upd_pkg::upd_out_t r0;
  upd_pkg::upd_out_t r1;
  upd_pkg::upd_state_t st;

  always_comb begin
    st        = st_i;
    hx        = hex_decode(byte_i);
    wc_plus1  = {1'b0, st_i.written_count} + 14'd1;
    active    = !st_i.error_seen && (st_i.written_count < cap_i);
    emit_lit  = 1'b0;
    do_plain  = 1'b0;
    emit_main = 1'b0;
    main_byte = byte_i;
    r0        = '0;
    r1        = '0;
    n         = 2'd0;

    if (active) begin
      unique case (st_i.phase)
        upd_pkg::PH_PCT: begin
          if (hx[4]) begin
            st.high_nibble = hx[3:0];
            st.phase       = upd_pkg::PH_HEX1;
          end else begin
            st.phase = upd_pkg::PH_TEXT;
            emit_lit = 1'b1;
            do_plain = wc_plus1 < {1'b0, cap_i};
          end
        end
        upd_pkg::PH_HEX1: begin
          st.phase = upd_pkg::PH_TEXT;
          if (hx[4]) begin
            emit_main = 1'b1;
            main_byte = {st_i.high_nibble, hx[3:0]};
          end else begin
            st.error_seen = 1'b1;
          end
        end
        default: begin
          st.phase = upd_pkg::PH_TEXT;
          do_plain = 1'b1;
        end
      endcase
    end

    if (do_plain) begin
      if (st_i.units_seen != 13'h1FFF) begin
        st.units_seen = st_i.units_seen + 13'd1;
      end
      if (byte_i == upd_pkg::CHAR_PCT) begin
        st.phase = upd_pkg::PH_PCT;
      end else begin
        emit_main = 1'b1;
        main_byte = (byte_i == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : byte_i;
      end
    end

    // literal percent goes first, decoded byte second
    if (emit_lit) begin
      r0.out_byte  = upd_pkg::CHAR_PCT;
      r0.out_valid = 1'b1;
      n            = 2'd1;
      if (emit_main) begin
        r1.out_byte  = main_byte;
        r1.out_valid = 1'b1;
        n            = 2'd2;
      end
    end else if (emit_main) begin
      r0.out_byte  = main_byte;
      r0.out_valid = 1'b1;
      n            = 2'd1;
    end
    st.written_count = st_i.written_count + {11'd0, n};

    if (last_i) begin
      if (n == 2'd2) begin
        r1.string_end = 1'b1;
        r1.bad_escape = st.error_seen;
        r1.unit_count = st.error_seen ? 13'd0 : st.units_seen;
      end else begin
        // status rides on the only result, or on an empty one
        r0.string_end = 1'b1;
        r0.bad_escape = st.error_seen;
        r0.unit_count = st.error_seen ? 13'd0 : st.units_seen;
        n             = 2'd1;
      end
      st = '0;
    end

    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end else begin
      r0.run_last = 1'b1;
    end

    st_o   = st;
    res0_o = r0;
    res1_o = r1;
    n_o    = n;
  end

endmodule

`default_nettype wire

// ===== src/url_percent_decoder_top.sv =====
// URL percent decoder top level: string state, capacity register and result queue.
// Depends on upd_pkg and upd_decode.
// Results are registered in the result queue before they appear on out_valid_o.
// Throughput: one byte per cycle while the queue holds at most one result; a byte giving two
// results (literal percent) holds in_ready_o low while the three-entry result queue drains.
// Reset: string state cleared, queue emptied, max_out set to 4096.
`default_nettype none

module url_percent_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  upd_pkg::upd_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output upd_pkg::upd_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_wdata_i
);

  localparam int unsigned QDepth = 3;

  upd_pkg::upd_state_t st_q, st_d;
  logic [12:0]         max_out_q;
  logic [12:0]         cap;
  upd_pkg::upd_out_t   res0, res1;
  logic [1:0]          n_res;
  upd_pkg::upd_out_t   q_q [QDepth];
  upd_pkg::upd_out_t   q_d [QDepth];
  logic [1:0]          cnt_q, cnt_d;
  logic [1:0]          base;
  logic                acc;
  logic                pop;

  assign cap = (max_out_q < 13'(upd_pkg::MAX_LEN)) ? max_out_q : 13'(upd_pkg::MAX_LEN);

  upd_decode u_decode (
    .st_i   (st_q),
    .byte_i (in_data_i.in_byte),
    .last_i (in_data_i.in_last),
    .cap_i  (cap),
    .st_o   (st_d),
    .res0_o (res0),
    .res1_o (res1),
    .n_o    (n_res)
  );

  assign in_ready_o  = cnt_q <= 2'd1;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = q_q[0];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      q_d[0] = q_q[1];
      q_d[1] = q_q[2];
    end
    base  = cnt_q - {1'b0, pop};
    cnt_d = base;
    if (acc) begin
      if (n_res != 2'd0) begin
        q_d[base] = res0;
      end
      if (n_res == 2'd2) begin
        q_d[base + 2'd1] = res1;
      end
      cnt_d = base + n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      cnt_q     <= 2'd0;
      max_out_q <= 13'(upd_pkg::MAX_LEN);
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        max_out_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed before its transaction");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.in_last) |=> (st_q == '0))
    else $error("string state not cleared after last byte");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.string_end) |-> out_data_o.run_last)
    else $error("string end result is not the last of its byte");

  a_err_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.error_seen |-> (st_q.phase == upd_pkg::PH_TEXT))
    else $error("escape phase active after error");

endmodule

`default_nettype wire
